### hw/rtl/alpha_blend_bitblt_defines.svh
// Assertion macros for the blit engine.
`ifndef ALPHA_BLEND_BITBLT_DEFINES_SVH
`define ALPHA_BLEND_BITBLT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ABB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ABB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ABB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ABB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/abb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abb_pkg;

   localparam int CHAN_W      = 8;
   localparam int LANES       = 3;
   localparam int PIX_W       = CHAN_W * LANES;
   localparam int SRC_W       = 32;
   localparam int OFF_W       = 21;
   localparam int DIM_W       = 11;
   localparam int REQ_DATA_W  = 2 * SRC_W;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   localparam int ROW_STRIDE_DEF  = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hff;
   localparam logic [CHAN_W-1:0] ALPHA_RESET = 8'hff;
   localparam logic [DIM_W-1:0]  DIM_RESET   = 11'd1;

   typedef enum logic [1:0] {
      REG_ALPHA,
      REG_WIDTH,
      REG_HEIGHT,
      REG_TRANSP
   } csr_reg_type;

   // Raster position info for one item.
   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic             row_end;
      logic             frame_end;
   } scan_info_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      scan_info_type    info;
   } rsp_item_type;

endpackage

`default_nettype wire

### hw/rtl/abb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One color channel: two-stage blend, (a*s + (255-a)*d) / 255.
module abb_lane (
   input  wire logic                       clock,
   input  wire logic [abb_pkg::CHAN_W-1:0] alpha,
   input  wire logic [abb_pkg::CHAN_W-1:0] src_chan,
   input  wire logic [abb_pkg::CHAN_W-1:0] dst_chan,
   output logic      [abb_pkg::CHAN_W-1:0] result
);

   localparam int PROD_W = 2 * abb_pkg::CHAN_W;

   logic [PROD_W-1:0]          prod_s_ff, prod_s_in;
   logic [PROD_W-1:0]          prod_d_ff, prod_d_in;
   logic [abb_pkg::CHAN_W-1:0] res_ff, res_in;
   logic [abb_pkg::CHAN_W-1:0] inv_alpha;
   logic [PROD_W-1:0]          sum;
   logic [PROD_W:0]            div_tmp;

   always_comb begin
      inv_alpha = abb_pkg::CHAN_MAX - alpha;
      prod_s_in = PROD_W'(alpha) * PROD_W'(src_chan);
      prod_d_in = PROD_W'(inv_alpha) * PROD_W'(dst_chan);
   end

   // Sum never exceeds 255*255; x/255 == (x + (x>>8) + 1) >> 8 over that range.
   always_comb begin
      sum     = prod_s_ff + prod_d_ff;
      div_tmp = (PROD_W+1)'(sum) + (PROD_W+1)'(sum[PROD_W-1:abb_pkg::CHAN_W])
                + (PROD_W+1)'(1);
      res_in  = abb_pkg::CHAN_W'(div_tmp >> abb_pkg::CHAN_W);
   end

   always_ff @(posedge clock) begin
      prod_s_ff <= prod_s_in;
      prod_d_ff <= prod_d_in;
      res_ff    <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

### hw/rtl/abb_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Raster walk over the rectangle; offset and end flags follow the lanes
// through two register stages.
module abb_scan #(
   parameter int ROW_STRIDE = abb_pkg::ROW_STRIDE_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [abb_pkg::DIM_W-1:0] rect_width,
   input  wire logic [abb_pkg::DIM_W-1:0] rect_height,
   output abb_pkg::scan_info_type         info
);

   localparam logic [abb_pkg::OFF_W-1:0] STRIDE_C = abb_pkg::OFF_W'(ROW_STRIDE);

   logic [abb_pkg::DIM_W-1:0] col_ff, col_in;
   logic [abb_pkg::DIM_W-1:0] row_ff, row_in;
   logic [abb_pkg::DIM_W-1:0] last_col, last_row;
   logic                      rend, fend;

   logic [abb_pkg::DIM_W-1:0] s1_col_ff;
   logic [abb_pkg::OFF_W-1:0] s1_prod_ff, s1_prod_in;
   logic                      s1_rend_ff, s1_fend_ff;
   abb_pkg::scan_info_type    s2_info_ff, s2_info_in;

   always_comb begin
      last_col = (rect_width == '0) ? '0 : rect_width - abb_pkg::DIM_W'(1);
      last_row = (rect_height == '0) ? '0 : rect_height - abb_pkg::DIM_W'(1);
      rend     = (col_ff >= last_col);
      fend     = rend && (row_ff >= last_row);
      col_in   = col_ff;
      row_in   = row_ff;
      if (advance) begin
         if (rend) begin
            col_in = '0;
            row_in = fend ? '0 : row_ff + abb_pkg::DIM_W'(1);
         end else begin
            col_in = col_ff + abb_pkg::DIM_W'(1);
         end
      end
      s1_prod_in = abb_pkg::OFF_W'(row_ff) * STRIDE_C;
   end

   always_comb begin
      s2_info_in.offset    = s1_prod_ff + abb_pkg::OFF_W'(s1_col_ff);
      s2_info_in.row_end   = s1_rend_ff;
      s2_info_in.frame_end = s1_fend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff  <= col_ff;
      s1_prod_ff <= s1_prod_in;
      s1_rend_ff <= rend;
      s1_fend_ff <= fend;
      s2_info_ff <= s2_info_in;
   end

   assign info = s2_info_ff;

endmodule

`default_nettype wire

### hw/rtl/abb_outq.sv
`timescale 1ns / 1ps
`default_nettype none

// Result queue between the lane pipeline and the output channel.
module abb_outq #(
   parameter int DEPTH = abb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire abb_pkg::rsp_item_type wr_item,
   input  wire logic                  rd_en,
   output logic                       rd_valid,
   output abb_pkg::rsp_item_type      rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   abb_pkg::rsp_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_rd;

   always_comb begin
      do_rd     = rd_en && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(wr_en) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_item  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hw/rtl/alpha_blend_bitblt.sv
`timescale 1ns / 1ps
`default_nettype none

`include "alpha_blend_bitblt_defines.svh"

// Alpha-blend blit engine. Each item carries one ARGB8888 source pixel and one
// destination pixel; the block walks the configured rectangle in row-major order
// and returns the blended RGB888 pixel, its frame offset (column + row*ROW_STRIDE,
// modulo 2^21) and end-of-row (tuser) / end-of-frame (tlast) flags. Three channel
// lanes blend in parallel, so one item is taken per clock when req_tready is high.
// Results pass the lane product and result registers into a QUEUE_DEPTH-entry
// result queue that absorbs output stalls; req_tready drops only when that many
// items are outstanding. Registers are to be written over the APB port only while
// the block is idle, which it does not enforce; new values apply to later items.
module alpha_blend_bitblt #(
   parameter int ROW_STRIDE  = abb_pkg::ROW_STRIDE_DEF,
   parameter int QUEUE_DEPTH = abb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input item channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [abb_pkg::REQ_DATA_W-1:0] req_tdata,   // source_pixel, backdrop_pixel
   // Result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [abb_pkg::RSP_DATA_W-1:0] rsp_tdata,   // blended_pixel, frame_offset, pad
   output logic                                rsp_tuser,   // row_end
   output logic                                rsp_tlast,   // frame_end
   // Register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [abb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [abb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [abb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

   logic [abb_pkg::CHAN_W-1:0] alpha_ff, alpha_in;
   logic [abb_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [abb_pkg::DIM_W-1:0]  height_ff, height_in;
   logic                       transp_ff, transp_in;

   logic                       csr_wr;
   abb_pkg::csr_reg_type       csr_sel;

   logic [abb_pkg::SRC_W-1:0]  src_pix, dst_pix;
   logic [abb_pkg::CHAN_W-1:0] eff_alpha;
   logic [abb_pkg::PIX_W-1:0]  blended;
   logic                       req_acc, rsp_acc;
   logic                       v1_ff, v2_ff;
   logic [CNT_W-1:0]           pending_ff, pending_in;

   abb_pkg::scan_info_type     scan_info;
   abb_pkg::rsp_item_type      q_wr_item, q_rd_item;
   logic                       q_valid;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = abb_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      alpha_in  = alpha_ff;
      width_in  = width_ff;
      height_in = height_ff;
      transp_in = transp_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            abb_pkg::REG_ALPHA:  alpha_in  = csr_pwdata[abb_pkg::CHAN_W-1:0];
            abb_pkg::REG_WIDTH:  width_in  = csr_pwdata[abb_pkg::DIM_W-1:0];
            abb_pkg::REG_HEIGHT: height_in = csr_pwdata[abb_pkg::DIM_W-1:0];
            abb_pkg::REG_TRANSP: transp_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         abb_pkg::REG_ALPHA:  csr_prdata = abb_pkg::CSR_DATA_W'(alpha_ff);
         abb_pkg::REG_WIDTH:  csr_prdata = abb_pkg::CSR_DATA_W'(width_ff);
         abb_pkg::REG_HEIGHT: csr_prdata = abb_pkg::CSR_DATA_W'(height_ff);
         abb_pkg::REG_TRANSP: csr_prdata = abb_pkg::CSR_DATA_W'(transp_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= abb_pkg::ALPHA_RESET;
         width_ff  <= abb_pkg::DIM_RESET;
         height_ff <= abb_pkg::DIM_RESET;
         transp_ff <= 1'b0;
      end else begin
         alpha_ff  <= alpha_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         transp_ff <= transp_in;
      end
   end

   // ---------------- flow control ----------------
   // pending counts items accepted and not yet delivered; it bounds queue fill.
   assign req_tready = (pending_ff < CNT_MAX);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         pending_ff <= '0;
      end else begin
         v1_ff      <= req_acc;
         v2_ff      <= v1_ff;
         pending_ff <= pending_in;
      end
   end

   // ---------------- lanes ----------------
   assign src_pix = req_tdata[abb_pkg::SRC_W-1:0];
   assign dst_pix = req_tdata[abb_pkg::REQ_DATA_W-1:abb_pkg::SRC_W];

   // Transparent source key: when enabled, a zero alpha byte passes the destination through.
   assign eff_alpha = (transp_ff && (src_pix[abb_pkg::SRC_W-1 -: abb_pkg::CHAN_W] == '0))
                      ? '0 : alpha_ff;

   for (genvar i = 0; i < abb_pkg::LANES; i++) begin : g_lane
      abb_lane u_lane (
         .clock    (clock),
         .alpha    (eff_alpha),
         .src_chan (src_pix[i*abb_pkg::CHAN_W +: abb_pkg::CHAN_W]),
         .dst_chan (dst_pix[i*abb_pkg::CHAN_W +: abb_pkg::CHAN_W]),
         .result   (blended[i*abb_pkg::CHAN_W +: abb_pkg::CHAN_W])
      );
   end

   abb_scan #(
      .ROW_STRIDE (ROW_STRIDE)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_acc),
      .rect_width  (width_ff),
      .rect_height (height_ff),
      .info        (scan_info)
   );

   // ---------------- merge and output ----------------
   assign q_wr_item.pixel = blended;
   assign q_wr_item.info  = scan_info;

   abb_outq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (v2_ff),
      .wr_item  (q_wr_item),
      .rd_en    (rsp_tready),
      .rd_valid (q_valid),
      .rd_item  (q_rd_item)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tdata  = abb_pkg::RSP_DATA_W'({q_rd_item.info.offset, q_rd_item.pixel});
   assign rsp_tuser  = q_rd_item.info.row_end;
   assign rsp_tlast  = q_rd_item.info.frame_end;

   // ---------------- checks ----------------
   `ABB_ASSERT_IMPLY(a_pending_bound, clock, reset, 1'b1, pending_ff <= CNT_MAX)
   `ABB_ASSERT_IMPLY(a_valid_pending, clock, reset, rsp_tvalid, pending_ff != '0)
   `ABB_ASSERT_IMPLY(a_frame_row_end, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   `ABB_ASSERT_NEXT(a_pending_inc, clock, reset, req_acc && !rsp_acc, pending_ff == CNT_W'($past(pending_ff) + CNT_W'(1)))

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int ROW_PITCH     = 1024;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1250;

   typedef enum int {
      FLOW_FREE,
      FLOW_SRC_GAPS,
      FLOW_DST_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   // Same layout as req_tdata: source in the low word.
   typedef struct packed {
      logic [abb_pkg::SRC_W-1:0] backdrop;
      logic [abb_pkg::SRC_W-1:0] source;
   } pixel_pair_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [abb_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // source_pixel, backdrop_pixel
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [abb_pkg::RSP_DATA_W-1:0] rsp_tdata;        // blended_pixel, frame_offset, pad
   logic                           rsp_tuser;        // row_end
   logic                           rsp_tlast;        // frame_end
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [abb_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [abb_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [abb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // predictor copy of the registers and raster position
   logic [abb_pkg::CHAN_W-1:0] cfg_alpha = abb_pkg::ALPHA_RESET;
   logic [abb_pkg::DIM_W-1:0]  cfg_width = abb_pkg::DIM_RESET;
   logic [abb_pkg::DIM_W-1:0]  cfg_height = abb_pkg::DIM_RESET;
   logic                       cfg_transp = 1'b0;
   logic [abb_pkg::DIM_W-1:0]  col_pos = '0;
   logic [abb_pkg::DIM_W-1:0]  row_pos = '0;

   pixel_pair_type        pending_pairs[$];
   abb_pkg::rsp_item_type blend_expect[$];
   flow_mode_type         flow = FLOW_FREE;
   int                    mismatch_count = 0;
   int                    quiet_cycles = 0;

   alpha_blend_bitblt #(
      .ROW_STRIDE(ROW_PITCH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic logic [abb_pkg::CHAN_W-1:0] mix_lane(logic [abb_pkg::CHAN_W-1:0] s,
                                                           logic [abb_pkg::CHAN_W-1:0] d,
                                                           logic [abb_pkg::CHAN_W-1:0] a);
      int unsigned ws, wd, wa;
      ws = s;
      wd = d;
      wa = a;
      return abb_pkg::CHAN_W'((wa * ws + (abb_pkg::CHAN_MAX - wa) * wd) / abb_pkg::CHAN_MAX);
   endfunction

   // Blends one pixel pair and steps the raster walk.
   function automatic abb_pkg::rsp_item_type predict_blend(pixel_pair_type p);
      abb_pkg::rsp_item_type      r;
      logic [abb_pkg::CHAN_W-1:0] weight;
      logic [abb_pkg::DIM_W-1:0]  last_col, last_row;
      int unsigned                lin;
      weight = cfg_alpha;
      if (cfg_transp && p.source[abb_pkg::SRC_W-1 -: abb_pkg::CHAN_W] == '0) begin
         weight = '0;
      end
      for (int k = 0; k < abb_pkg::LANES; k++) begin
         r.pixel[k*abb_pkg::CHAN_W +: abb_pkg::CHAN_W] =
            mix_lane(p.source[k*abb_pkg::CHAN_W +: abb_pkg::CHAN_W],
                     p.backdrop[k*abb_pkg::CHAN_W +: abb_pkg::CHAN_W], weight);
      end
      // zero width or height acts as one
      last_col = (cfg_width == '0) ? '0 : cfg_width - 1'b1;
      last_row = (cfg_height == '0) ? '0 : cfg_height - 1'b1;
      lin = col_pos + row_pos * ROW_PITCH;
      r.info.offset = abb_pkg::OFF_W'(lin);
      r.info.row_end = col_pos >= last_col;
      r.info.frame_end = r.info.row_end && row_pos >= last_row;
      if (r.info.row_end) begin
         col_pos = '0;
         row_pos = r.info.frame_end ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   // Input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() != 0 &&
             !(flow == FLOW_SRC_GAPS && roll(68)) && !(flow == FLOW_BOTH && roll(19))) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (flow)
            FLOW_DST_STALLS: rsp_tready <= !roll(68);
            FLOW_BOTH: rsp_tready <= !roll(19);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Monitor: predict on input accept, compare on result accept
   always @(posedge clock) begin
      abb_pkg::rsp_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            blend_expect.push_back(predict_blend(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (blend_expect.size() == 0) begin
               report_mismatch("result with none expected", rsp_tdata, '0);
            end else begin
               want = blend_expect.pop_front();
               if (rsp_tdata[abb_pkg::PIX_W-1:0] !== want.pixel)
                  report_mismatch("blended_pixel", rsp_tdata[abb_pkg::PIX_W-1:0], want.pixel);
               if (rsp_tdata[abb_pkg::PIX_W +: abb_pkg::OFF_W] !== want.info.offset)
                  report_mismatch("frame_offset", rsp_tdata[abb_pkg::PIX_W +: abb_pkg::OFF_W],
                                  want.info.offset);
               if (rsp_tuser !== want.info.row_end)
                  report_mismatch("row_end", rsp_tuser, want.info.row_end);
               if (rsp_tlast !== want.info.frame_end)
                  report_mismatch("frame_end", rsp_tlast, want.info.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(abb_pkg::csr_reg_type which,
                            logic [abb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (which)
         abb_pkg::REG_ALPHA: cfg_alpha = value[abb_pkg::CHAN_W-1:0];
         abb_pkg::REG_WIDTH: cfg_width = value[abb_pkg::DIM_W-1:0];
         abb_pkg::REG_HEIGHT: cfg_height = value[abb_pkg::DIM_W-1:0];
         abb_pkg::REG_TRANSP: cfg_transp = value[0];
         default: ;
      endcase
   endtask

   task automatic set_frame(logic [abb_pkg::CHAN_W-1:0] alpha, logic [abb_pkg::DIM_W-1:0] width,
                            logic [abb_pkg::DIM_W-1:0] height, logic transp);
      write_reg(abb_pkg::REG_ALPHA, alpha);
      write_reg(abb_pkg::REG_WIDTH, width);
      write_reg(abb_pkg::REG_HEIGHT, height);
      write_reg(abb_pkg::REG_TRANSP, transp);
   endtask

   task automatic push_pixels(logic [abb_pkg::SRC_W-1:0] src, logic [abb_pkg::SRC_W-1:0] dst);
      pending_pairs.push_back({dst, src});
   endtask

   // Block is idle once all items are out and every result is back.
   task automatic drain();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || blend_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Small dimensions mostly; zero and the maximum now and then.
   function automatic logic [abb_pkg::CSR_DATA_W-1:0] pick_dim(int hi);
      logic [abb_pkg::CSR_DATA_W-1:0] v;
      case ($urandom_range(11))
         0: v = 0;
         1: v = 2047;
         2: v = 1;
         default: v = $urandom_range(2, hi);
      endcase
      if ($urandom_range(7) == 0) v = v | ($urandom & 32'hffff_f800);
      return v;
   endfunction

   initial begin
      int                             sent;
      int                             count;
      int                             phase;
      logic [abb_pkg::SRC_W-1:0]      src;
      logic [abb_pkg::CSR_DATA_W-1:0] v;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single-pixel frame, full source weight
      push_pixels(32'h0000_0000, 32'h0000_0000);
      push_pixels(32'hffff_ffff, 32'hffff_ffff);
      push_pixels(32'h00ff_00ff, 32'hff00_ff00);
      drain();

      // zero alpha: backdrop passes whatever the source
      set_frame(8'd0, 11'd3, 11'd2, 1'b1);
      push_pixels(32'hffff_ffff, 32'h0000_0000);
      push_pixels(32'h00ff_ffff, 32'hff12_3456);
      push_pixels(32'h0100_0000, 32'hffff_ffff);
      push_pixels(32'h8080_8080, 32'h7f7f_7f7f);
      push_pixels(32'hff00_0000, 32'h00ff_ffff);
      push_pixels(32'h0000_0000, 32'h0000_0000);
      drain();

      // half weight, transparent and opaque source, zero dimensions
      set_frame(8'd128, 11'd0, 11'd0, 1'b1);
      push_pixels(32'h00ff_ffff, 32'h0000_0000);
      push_pixels(32'h01ff_ffff, 32'h0000_0000);
      push_pixels(32'hffff_ffff, 32'hffff_ffff);
      drain();

      set_frame(8'd255, 11'd2047, 11'd2047, 1'b0);
      push_pixels(32'h00ab_cdef, 32'hff00_0000);
      push_pixels(32'hffff_ffff, 32'h0000_0000);
      push_pixels(32'h0000_0000, 32'hffff_ffff);
      drain();

      // shrink the rectangle mid-frame, past the current column then row
      set_frame(8'd77, 11'd8, 11'd4, 1'b0);
      repeat (5) push_pixels($urandom, $urandom);
      drain();
      write_reg(abb_pkg::REG_WIDTH, 32'd3);
      repeat (2) push_pixels($urandom, $urandom);
      drain();
      write_reg(abb_pkg::REG_HEIGHT, 32'd1);
      repeat (3) push_pixels($urandom, $urandom);
      drain();

      // deep rows: one pixel per row, tallest rectangle
      set_frame($urandom, 11'd1, 11'd2047, 1'b1);
      flow = FLOW_BOTH;
      for (int i = 0; i < 160; i++) push_pixels($urandom, $urandom);
      sent = 160;
      drain();

      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         flow = flow_mode_type'(phase % 4);
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
               0: v = 0;
               1: v = 255;
               default: v = $urandom_range(255);
            endcase
            if ($urandom_range(7) == 0) v = v | ($urandom & 32'hffff_ff00);
            write_reg(abb_pkg::REG_ALPHA, v);
         end
         if ($urandom_range(3) != 0) write_reg(abb_pkg::REG_WIDTH, pick_dim(12));
         if ($urandom_range(3) != 0) write_reg(abb_pkg::REG_HEIGHT, pick_dim(6));
         if ($urandom_range(2) != 0) write_reg(abb_pkg::REG_TRANSP, $urandom);
         count = $urandom_range(20, 80);
         for (int i = 0; i < count; i++) begin
            src = $urandom;
            if (roll(30)) src[abb_pkg::SRC_W-1 -: abb_pkg::CHAN_W] = '0;
            push_pixels(src, $urandom);
         end
         sent += count;
         phase++;
         drain();
      end

      if (blend_expect.size() != 0) begin
         report_mismatch("results never returned", blend_expect.size(), '0);
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/abb_pkg.sv
hw/rtl/abb_lane.sv
hw/rtl/abb_scan.sv
hw/rtl/abb_outq.sv
hw/rtl/alpha_blend_bitblt.sv
verif/testbench.sv
